// ----- sv/binary_to_bcd_96bit_assert.svh -----
// Assertion macros for the binary-to-BCD converter.
// Included by the top level; depends on nothing else.
`ifndef BINARY_TO_BCD_96BIT_ASSERT_SVH
`define BINARY_TO_BCD_96BIT_ASSERT_SVH

// Antecedent implies consequent a fixed number of cycles later.
`define B2BCD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##dly (cons)) else $error("b2bcd: %m check failed");

// Antecedent implies consequent in the same cycle.
`define B2BCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error("b2bcd: %m check failed");

`endif

// ----- sv/b2bcd_pkg.sv -----
// Shared types and constants of the binary-to-BCD converter.
// No dependencies.
package b2bcd_pkg;

    localparam int BIN_WIDTH_DEF   = 96;
    localparam int DIGIT_COUNT_DEF = 29;
    localparam int BIN_WIDTH_MAX   = 96;
    localparam int DIGIT_COUNT_MAX = 29;
    localparam int WORD_W          = 32;
    localparam int DIGIT_W         = 4;
    localparam int LOW_DIGITS      = 16;
    localparam int HIGH_DIGITS     = 13;

    typedef logic [DIGIT_W-1:0] t_digit;

    localparam t_digit DIGIT_HALF = t_digit'(5);
    localparam t_digit DIGIT_TEN  = t_digit'(10);

endpackage

// ----- sv/b2bcd_cell.sv -----
// One decimal digit cell: doubles its digit and adds the carry from below.
// Depends on b2bcd_pkg.
module b2bcd_cell (
    input  logic              i_clk,
    input  b2bcd_pkg::t_digit i_digit,
    input  logic              i_carry,
    output logic              o_carry,
    output b2bcd_pkg::t_digit o_digit
);
    import b2bcd_pkg::*;

    t_digit n_digit;
    t_digit r_digit;

    always_comb begin
        o_carry = (i_digit >= DIGIT_HALF);
        if (o_carry) begin
            n_digit = t_digit'({i_digit[DIGIT_W-2:0], i_carry} - DIGIT_TEN);
        end else begin
            n_digit = {i_digit[DIGIT_W-2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

// ----- sv/b2bcd_stage.sv -----
// One step of the converter: a row of digit cells fed by the next binary bit.
// Depends on b2bcd_pkg and b2bcd_cell.
module b2bcd_stage #(
    parameter int BIN_WIDTH   = b2bcd_pkg::BIN_WIDTH_DEF,
    parameter int DIGIT_COUNT = b2bcd_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic [BIN_WIDTH-1:0]                     i_bits,
    input  b2bcd_pkg::t_digit [DIGIT_COUNT-1:0]      i_digits,
    output logic                                     o_valid,
    output logic [BIN_WIDTH-1:0]                     o_bits,
    output b2bcd_pkg::t_digit [DIGIT_COUNT-1:0]      o_digits
);
    import b2bcd_pkg::*;

    logic                 r_valid;
    logic [BIN_WIDTH-1:0] r_bits;
    logic [DIGIT_COUNT:0] carry;

    assign carry[0] = i_bits[BIN_WIDTH-1];

    for (genvar j = 0; j < DIGIT_COUNT; j++) begin : g_cell
        b2bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_digit (i_digits[j]),
            .i_carry (carry[j]),
            .o_carry (carry[j+1]),
            .o_digit (o_digits[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= {i_bits[BIN_WIDTH-2:0], carry[DIGIT_COUNT]};
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;

endmodule

// ----- sv/binary_to_bcd_96bit.sv -----
// Binary-to-BCD converter, top level: a chain of BIN_WIDTH digit-cell stages.
// Depends on b2bcd_pkg, b2bcd_stage and binary_to_bcd_96bit_assert.svh.
//
// Converts an unsigned BIN_WIDTH-bit value, given as three 32-bit words, into
// DIGIT_COUNT packed BCD digits. A beat is taken at every clock edge where
// start is high; busy is high only while reset is held. Each beat passes one
// stage per cycle through a chain of BIN_WIDTH stages, one stage per binary
// bit, so its result leaves the last stage with o_done high
// for one cycle. A new beat may enter every cycle and results leave in order;
// the receiver cannot stall, so it must take each result in its o_done cycle.
// Input bits at and above BIN_WIDTH are ignored, the result is the value
// modulo 10^DIGIT_COUNT, and digit positions at and above DIGIT_COUNT read 0.
module binary_to_bcd_96bit #(
    parameter int BIN_WIDTH   = b2bcd_pkg::BIN_WIDTH_DEF,
    parameter int DIGIT_COUNT = b2bcd_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          start,
    output logic                                          busy,
    input  logic [b2bcd_pkg::WORD_W-1:0]                  i_low_word,
    input  logic [b2bcd_pkg::WORD_W-1:0]                  i_mid_word,
    input  logic [b2bcd_pkg::WORD_W-1:0]                  i_high_word,
    output logic                                          o_done,
    output logic [b2bcd_pkg::LOW_DIGITS*b2bcd_pkg::DIGIT_W-1:0]  o_bcd_low,
    output logic [b2bcd_pkg::HIGH_DIGITS*b2bcd_pkg::DIGIT_W-1:0] o_bcd_high
);
    import b2bcd_pkg::*;

    `include "binary_to_bcd_96bit_assert.svh"

    localparam int ALL_DIGITS = LOW_DIGITS + HIGH_DIGITS;

    logic                                  accept;
    logic [3*WORD_W-1:0]                   in_value;
    logic [BIN_WIDTH:0]                    valid;
    logic [BIN_WIDTH:0][BIN_WIDTH-1:0]     bits;
    t_digit [BIN_WIDTH:0][DIGIT_COUNT-1:0] digits;
    t_digit [ALL_DIGITS-1:0]               out_digits;
    logic                                  in_zero;
    logic                                  out_zero;

    assign busy     = ~i_rst_n;
    assign accept   = start & ~busy;
    assign in_value = {i_high_word, i_mid_word, i_low_word};

    assign valid[0]  = accept;
    assign bits[0]   = in_value[BIN_WIDTH-1:0];
    assign digits[0] = '0;

    for (genvar k = 0; k < BIN_WIDTH; k++) begin : g_stage
        b2bcd_stage #(
            .BIN_WIDTH   (BIN_WIDTH),
            .DIGIT_COUNT (DIGIT_COUNT)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (valid[k]),
            .i_bits   (bits[k]),
            .i_digits (digits[k]),
            .o_valid  (valid[k+1]),
            .o_bits   (bits[k+1]),
            .o_digits (digits[k+1])
        );
    end

    for (genvar j = 0; j < ALL_DIGITS; j++) begin : g_out
        if (j < DIGIT_COUNT) begin : g_used
            assign out_digits[j] = digits[BIN_WIDTH][j];
        end else begin : g_zero
            assign out_digits[j] = '0;
        end
    end

    assign o_done     = valid[BIN_WIDTH];
    assign o_bcd_low  = out_digits[LOW_DIGITS-1:0];
    assign o_bcd_high = out_digits[ALL_DIGITS-1:LOW_DIGITS];

    assign in_zero  = (in_value[BIN_WIDTH-1:0] == '0);
    assign out_zero = (o_bcd_low == '0) && (o_bcd_high == '0);

    `B2BCD_ASSERT_DELAY(a_latency, i_clk, i_rst_n, accept, BIN_WIDTH, o_done)
    `B2BCD_ASSERT_DELAY(a_zero_in, i_clk, i_rst_n, accept && in_zero, BIN_WIDTH, out_zero)
    `B2BCD_ASSERT_IMPL(a_digit_ok, i_clk, i_rst_n, o_done, o_bcd_low[DIGIT_W-1:0] <= t_digit'(9))

endmodule
